// ===== rtl/byte_ring_fifo_burst_read_assert.svh =====
// assertion macros used by the fifo datapath
`ifndef BYTE_RING_FIFO_BURST_READ_ASSERT_SVH
`define BYTE_RING_FIFO_BURST_READ_ASSERT_SVH

// expression must hold at every clock edge outside reset
`define BRF_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/brf_pkg.sv =====
package brf_pkg;

    // default sizes
    localparam int unsigned DEF_STORE_DEPTH = 256;
    localparam int unsigned DEF_MAX_BURST   = 64;

    // field widths
    localparam int unsigned CFG_W       = 9;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 7;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 24;

    // requested size after reset
    localparam int unsigned RST_SIZE_REQ = 256;

    // action codes carried in the input tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_NONE = 2'd2
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_BURST = 1'b1
    } t_ctrl_state;

    // commands from controller to datapath
    typedef struct packed {
        logic do_write;
        logic do_nothing;
        logic load_burst;
        logic do_read;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic slot_free;
        logic out_busy;
        logic burst_zero;
        logic burst_last;
    } t_dp_sts;

endpackage

// ===== rtl/brf_ctrl.sv =====
module brf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    input  logic             i_cfg_valid,
    input  brf_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output logic             o_cfg_ready,
    output brf_pkg::t_dp_cmd o_cmd
);
    import brf_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        in_accept;

    // config has priority over new items
    assign in_accept = i_in_valid && o_in_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_action == ACT_READ) && !i_sts.burst_zero) begin
                    n_state = S_BURST;
                end
            end
            S_BURST: begin
                if (i_sts.slot_free && i_sts.burst_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = i_sts.slot_free && !i_cfg_valid;
                o_cfg_ready = !i_sts.out_busy;
                if (in_accept) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.do_write = 1'b1;
                    end else if (i_sts.burst_zero) begin
                        o_cmd.do_nothing = 1'b1;
                    end else begin
                        o_cmd.load_burst = 1'b1;
                    end
                end
            end
            S_BURST: begin
                o_cmd.do_read = i_sts.slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/brf_datapath.sv =====
`include "byte_ring_fifo_burst_read_assert.svh"

module brf_datapath #(
    parameter int unsigned STORE_DEPTH = brf_pkg::DEF_STORE_DEPTH,
    parameter int unsigned MAX_BURST   = brf_pkg::DEF_MAX_BURST
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [brf_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [brf_pkg::BYTE_W-1:0]   i_write_data,
    input  logic [brf_pkg::LEN_W-1:0]    i_read_length,
    input  brf_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_out_ready,
    output brf_pkg::t_dp_sts             o_sts,
    output logic                         o_out_valid,
    output logic [brf_pkg::STATUS_W-1:0] o_status,
    output logic [brf_pkg::BYTE_W-1:0]   o_read_data,
    output logic                         o_data_valid,
    output logic                         o_last,
    output logic [brf_pkg::BYTE_W-1:0]   o_bytes_held,
    output logic                         o_full,
    output logic                         o_empty
);
    import brf_pkg::*;

    localparam int unsigned PTR_W    = $clog2(STORE_DEPTH);
    localparam int unsigned CNT_W    = $clog2(STORE_DEPTH + 1);
    localparam int unsigned BURST_W  = $clog2(MAX_BURST + 1);
    localparam int unsigned RST_SIZE = (RST_SIZE_REQ > STORE_DEPTH) ? STORE_DEPTH
                                                                    : RST_SIZE_REQ;

    // pointer step with wrap at the ring size
    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] s);
        logic [CNT_W-1:0] p_inc;
        p_inc = CNT_W'(p) + CNT_W'(1);
        return (p_inc == s) ? '0 : PTR_W'(p_inc);
    endfunction

    // byte store
    logic [BYTE_W-1:0]  r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]  r_mem_q;

    // ring state
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_ring_size;
    logic [BURST_W-1:0] r_burst_left;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_dvalid;
    logic               r_out_last;
    logic [BYTE_W-1:0]  r_out_count;
    logic               r_out_full;
    logic               r_out_empty;

    logic               is_full;
    logic               slot_free;
    logic               result_load;
    logic [CNT_W-1:0]   cfg_size;
    logic [BURST_W-1:0] len_sat;
    logic [BURST_W-1:0] burst_n;
    logic [CNT_W-1:0]   n_count;
    t_status            n_status;

    assign is_full     = (r_count == (r_ring_size - CNT_W'(1)));
    assign slot_free   = !r_out_valid || i_out_ready;
    assign result_load = i_cmd.do_write || i_cmd.do_nothing || i_cmd.do_read;

    // clamp the requested size into the store
    always_comb begin
        if (i_cfg_data < CFG_W'(2)) begin
            cfg_size = CNT_W'(2);
        end else if (32'(i_cfg_data) > STORE_DEPTH) begin
            cfg_size = CNT_W'(STORE_DEPTH);
        end else begin
            cfg_size = CNT_W'(i_cfg_data);
        end
    end

    // burst length: saturated request limited by bytes held
    always_comb begin
        if (32'(i_read_length) > MAX_BURST) begin
            len_sat = BURST_W'(MAX_BURST);
        end else begin
            len_sat = BURST_W'(i_read_length);
        end
        if (32'(r_count) < 32'(len_sat)) begin
            burst_n = BURST_W'(r_count);
        end else begin
            burst_n = len_sat;
        end
    end

    // byte count and status after this result
    always_comb begin
        n_count  = r_count;
        n_status = STAT_OK;
        if (i_cmd.do_write) begin
            if (is_full) begin
                n_status = STAT_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (i_cmd.do_nothing) begin
            n_status = STAT_NONE;
        end else if (i_cmd.do_read) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.slot_free  = slot_free;
        o_sts.out_busy   = r_out_valid;
        o_sts.burst_zero = (burst_n == '0);
        o_sts.burst_last = (r_burst_left == BURST_W'(1));
    end

    // store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && !is_full) begin
            r_mem[r_wr_ptr] <= i_write_data;
        end
    end

    // store read port, held while the output stalls
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_read) begin
            r_mem_q <= r_mem[r_rd_ptr];
        end
    end

    // pointers, count, size and burst counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_count      <= '0;
            r_ring_size  <= CNT_W'(RST_SIZE);
            r_burst_left <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ring_size <= cfg_size;
                r_rd_ptr    <= '0;
                r_wr_ptr    <= '0;
                r_count     <= '0;
            end else if (i_cmd.do_write && !is_full) begin
                r_wr_ptr <= ptr_adv(r_wr_ptr, r_ring_size);
                r_count  <= n_count;
            end else if (i_cmd.do_read) begin
                r_rd_ptr <= ptr_adv(r_rd_ptr, r_ring_size);
                r_count  <= n_count;
            end
            if (i_cmd.load_burst) begin
                r_burst_left <= burst_n;
            end else if (i_cmd.do_read) begin
                r_burst_left <= r_burst_left - BURST_W'(1);
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= result_load;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (result_load) begin
            r_out_status <= n_status;
            r_out_dvalid <= i_cmd.do_read;
            r_out_last   <= i_cmd.do_read ? (r_burst_left == BURST_W'(1)) : 1'b1;
            r_out_count  <= BYTE_W'(n_count);
            r_out_full   <= (n_count == (r_ring_size - CNT_W'(1)));
            r_out_empty  <= (n_count == '0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_data  = r_out_dvalid ? r_mem_q : '0;
    assign o_data_valid = r_out_dvalid;
    assign o_last       = r_out_last;
    assign o_bytes_held = r_out_count;
    assign o_full       = r_out_full;
    assign o_empty      = r_out_empty;

    // checks
    `BRF_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count < r_ring_size, "count past ring size")
    `BRF_ASSERT_ALWAYS(a_empty_ptrs, i_clk, i_rst_n, (r_count == '0) == (r_rd_ptr == r_wr_ptr), "count and pointers disagree")
    `BRF_ASSERT_IMPLY(a_read_has_data, i_clk, i_rst_n, i_cmd.do_read, (r_count != '0) && (r_burst_left != '0), "read issued with nothing to read")
    `BRF_ASSERT_IMPLY(a_data_ok, i_clk, i_rst_n, r_out_valid && r_out_dvalid, r_out_status == STAT_OK, "data result with bad status")

endmodule

// ===== rtl/byte_ring_fifo_burst_read.sv =====
// Byte FIFO on a circular store whose pointers wrap at a programmable size
// (2 up to STORE_DEPTH slots); one slot stays empty, so it holds size - 1
// bytes. An input transaction either writes one byte (tuser 0) or asks for a
// burst read of up to read_length bytes (tuser 1, capped at MAX_BURST).
// A write gives one result; a read with nothing to give gives one result;
// a burst of n bytes is first sized, then gives one byte a cycle, while
// the output does not stall, through the registered read port of the
// store. Results wait in an output register, and a stalled output
// holds the burst. Writing the size register empties the FIFO; it is taken
// only when no transaction is in progress and no result is waiting.
module byte_ring_fifo_burst_read #(
    parameter int unsigned STORE_DEPTH = brf_pkg::DEF_STORE_DEPTH,
    parameter int unsigned MAX_BURST   = brf_pkg::DEF_MAX_BURST
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // size register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [brf_pkg::CFG_W-1:0]     i_cfg_data,      // size_in_use
    // input items
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [brf_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // write_data, read_length, pad
    input  logic                          i_s_axis_tuser,  // action
    // results
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [brf_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // status, read_data,
                                                           // bytes_held, is_full,
                                                           // is_empty, pad
    output logic                          o_m_axis_tuser,  // data_valid
    output logic                          o_m_axis_tlast   // last_of_run
);
    import brf_pkg::*;

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic [BYTE_W-1:0]   write_data;
    logic [LEN_W-1:0]    read_length;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_data;
    logic [BYTE_W-1:0]   bytes_held;
    logic                is_full;
    logic                is_empty;

    // unpack input fields
    assign write_data  = i_s_axis_tdata[BYTE_W-1:0];
    assign read_length = i_s_axis_tdata[BYTE_W+LEN_W-1:BYTE_W];

    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_action    (i_s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (sts),
        .o_in_ready  (o_s_axis_tready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    brf_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_BURST   (MAX_BURST)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_write_data  (write_data),
        .i_read_length (read_length),
        .i_cmd         (cmd),
        .i_out_ready   (i_m_axis_tready),
        .o_sts         (sts),
        .o_out_valid   (o_m_axis_tvalid),
        .o_status      (status),
        .o_read_data   (read_data),
        .o_data_valid  (o_m_axis_tuser),
        .o_last        (o_m_axis_tlast),
        .o_bytes_held  (bytes_held),
        .o_full        (is_full),
        .o_empty       (is_empty)
    );

    // pack result fields
    assign o_m_axis_tdata = {4'b0, is_empty, is_full, bytes_held, read_data, status};

endmodule

// ===== bench/tb.sv =====
module tb;

    import brf_pkg::*;

    localparam int unsigned RING_MAX     = DEF_STORE_DEPTH;
    localparam int unsigned RING_IDX_W   = $clog2(RING_MAX);
    localparam int unsigned BURST_CAP    = DEF_MAX_BURST;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          MAX_PRINTS   = 60;

    // one input transaction
    typedef struct {
        logic            action;
        logic [7:0]      wdata;
        logic [6:0]      rlen;
    } t_fifo_op;

    // one result transaction
    typedef struct {
        t_status         status;
        logic [7:0]      rdata;
        logic            dvalid;
        logic            last;
        logic [7:0]      held;
        logic            full;
        logic            empty;
    } t_fifo_res;

    // result tdata layout, lowest field last
    typedef struct packed {
        logic [3:0]      pad;
        logic            empty;
        logic            full;
        logic [7:0]      held;
        logic [7:0]      rdata;
        logic [1:0]      status;
    } t_res_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    byte_ring_fifo_burst_read dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // shadow fifo state
    logic [7:0]     byte_mem [RING_MAX];
    int unsigned    rd_ptr = 0;
    int unsigned    wr_ptr = 0;
    int unsigned    ring_len = RING_MAX;

    t_fifo_op       ops_to_send[$];
    t_fifo_res      due_results[$];
    t_fifo_op       op_now;

    bit             op_took = 1'b0;
    bit             res_took = 1'b0;
    bit             hold_req = 1'b0;
    bit             quiet = 1'b0;
    int             op_gap = 0;
    int             res_wait = 0;
    int             hold_left = 0;
    int             mismatch_count = 0;
    int             idle_cycles = 0;

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    // idle cycles before the next transaction on either side
    function automatic int draw_gap();
        if (quiet)
            return 0;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 17);
            1: return $urandom_range(0, 2);
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned ring_next(int unsigned p);
        return (p + 1 >= ring_len) ? 0 : p + 1;
    endfunction

    function automatic int unsigned fill_level();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : ring_len - rd_ptr + wr_ptr;
    endfunction

    // result fields as they stand after the current state change
    function automatic t_fifo_res fifo_snapshot(t_status st, logic [7:0] data,
                                                logic dv, logic lst);
        t_fifo_res r;
        r.status = st;
        r.rdata  = data;
        r.dvalid = dv;
        r.last   = lst;
        r.held   = 8'(fill_level());
        r.full   = (ring_next(wr_ptr) == rd_ptr);
        r.empty  = (rd_ptr == wr_ptr);
        return r;
    endfunction

    // size write clamps and empties the fifo
    function automatic void set_ring_len(int unsigned v);
        ring_len = (v < 2) ? 2 : (v > RING_MAX) ? RING_MAX : v;
        rd_ptr = 0;
        wr_ptr = 0;
    endfunction

    // expected results of one accepted transaction
    function automatic void fifo_results_for(t_fifo_op op);
        int unsigned len;
        int unsigned n;
        logic [7:0]  b;
        if (op.action == ACT_WRITE) begin
            if (ring_next(wr_ptr) == rd_ptr) begin
                due_results.push_back(fifo_snapshot(STAT_FULL, 8'h00, 1'b0, 1'b1));
            end else begin
                byte_mem[RING_IDX_W'(wr_ptr)] = op.wdata;
                wr_ptr = ring_next(wr_ptr);
                due_results.push_back(fifo_snapshot(STAT_OK, 8'h00, 1'b0, 1'b1));
            end
        end else begin
            len = (op.rlen > BURST_CAP) ? BURST_CAP : op.rlen;
            n = (fill_level() < len) ? fill_level() : len;
            if (n == 0)
                due_results.push_back(fifo_snapshot(STAT_NONE, 8'h00, 1'b0, 1'b1));
            for (int unsigned i = 0; i < n; i++) begin
                b = byte_mem[RING_IDX_W'(rd_ptr)];
                rd_ptr = ring_next(rd_ptr);
                due_results.push_back(fifo_snapshot(STAT_OK, b, 1'b1, i + 1 == n));
            end
        end
    endfunction

    // sender: prediction on each accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            op_took = 1'b1;
            fifo_results_for(op_now);
        end
    end

    // sender: drive at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !op_took) begin
            // still offered, wait for acceptance
        end else begin
            if (op_took) begin
                op_took = 1'b0;
                op_gap = draw_gap();
            end
            if (op_gap > 0) begin
                op_gap = op_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (ops_to_send.size() != 0) begin
                op_now = ops_to_send.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {1'b0, op_now.rlen, op_now.wdata};
                i_s_axis_tuser  <= op_now.action;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: ready at the falling edge, long hold on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (res_took) begin
                res_took = 1'b0;
                res_wait = draw_gap();
            end
            if (res_wait > 0) begin
                res_wait = res_wait - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_res_word w;
        t_fifo_res e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            res_took = 1'b1;
            w = o_m_axis_tdata;
            if (due_results.size() == 0) begin
                log_mismatch($sformatf("result with nothing pending, tdata %h",
                                       o_m_axis_tdata));
            end else begin
                e = due_results.pop_front();
                if (w.status !== e.status)
                    log_mismatch($sformatf("status %0d want %0d", w.status, e.status));
                if (w.rdata !== e.rdata)
                    log_mismatch($sformatf("read_data %h want %h", w.rdata, e.rdata));
                if (o_m_axis_tuser !== e.dvalid)
                    log_mismatch($sformatf("data_valid %b want %b", o_m_axis_tuser,
                                           e.dvalid));
                if (o_m_axis_tlast !== e.last)
                    log_mismatch($sformatf("last_of_run %b want %b", o_m_axis_tlast,
                                           e.last));
                if (w.held !== e.held)
                    log_mismatch($sformatf("bytes_held %0d want %0d", w.held, e.held));
                if (w.full !== e.full)
                    log_mismatch($sformatf("is_full %b want %b", w.full, e.full));
                if (w.empty !== e.empty)
                    log_mismatch($sformatf("is_empty %b want %b", w.empty, e.empty));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic add_write(logic [7:0] d);
        t_fifo_op op;
        op.action = ACT_WRITE;
        op.wdata  = d;
        op.rlen   = 7'($urandom_range(0, 127));
        ops_to_send.push_back(op);
    endtask

    task automatic add_read(logic [6:0] n);
        t_fifo_op op;
        op.action = ACT_READ;
        op.wdata  = 8'($urandom_range(0, 255));
        op.rlen   = n;
        ops_to_send.push_back(op);
    endtask

    // sender pauses until every expected result has come
    task automatic drain();
        while (ops_to_send.size() != 0 || i_s_axis_tvalid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    // size register write, only while idle
    task automatic write_size(int unsigned v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        set_ring_len(v & 32'h1ff);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random mix of writes and bursts at one size
    task automatic run_phase(int unsigned size, int count, int write_pct, bit calm);
        write_size(size);
        quiet = calm;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1, 100) <= write_pct) begin
                add_write(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 19))
                    0:       add_read(7'd0);
                    1:       add_read(7'($urandom_range(65, 127)));
                    2, 3, 4: add_read(7'($urandom_range(17, 64)));
                    default: add_read(7'($urandom_range(1, 16)));
                endcase
            end
        end
        drain();
        quiet = 1'b0;
    endtask

    // stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: empty read, byte extremes, zero and oversized length
        add_read(7'd5);
        add_write(8'h00);
        add_write(8'hff);
        add_write(8'ha5);
        add_write(8'h5a);
        add_read(7'd0);
        add_read(7'd2);
        add_read(7'd127);
        add_read(7'd1);

        // size 4: fill, refused write, burst that wraps at the end of the ring
        write_size(4);
        add_write(8'h11);
        add_write(8'h22);
        add_write(8'h33);
        add_write(8'h44);
        add_read(7'd2);
        add_write(8'h55);
        add_write(8'h66);
        add_read(7'd2);
        add_read(7'd64);
        add_read(7'd3);

        // size below range is taken as two
        write_size(1);
        add_write(8'h80);
        add_write(8'h7f);
        add_read(7'd1);
        add_read(7'd1);

        run_phase(511, 20, 75, 1'b0);
        run_phase(0, 20, 55, 1'b0);
        run_phase(5, 20, 60, 1'b1);

        // long receiver hold while writes keep coming
        write_size(300);
        quiet = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            add_write(8'($urandom_range(0, 255)));
        drain();
        quiet = 1'b0;
        run_phase(256, 20, 30, 1'b0);

        run_phase(3, 20, 55, 1'b0);
        run_phase(17, 15, 60, 1'b0);
        run_phase($urandom_range(2, 256), 15, 65, 1'b0);
        run_phase($urandom_range(257, 511), 15, 80, 1'b1);
        run_phase(2, 15, 50, 1'b0);

        drain();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
